FILE: hdl/spq_pkg.sv
// Package for the sorted priority queue: sizes, word layouts, request and
// status codes, and the control bundle broadcast to the row of cells.
// No dependencies.
package spq_pkg;

	localparam int CAPACITY = 64;
	localparam int TAG_W    = 32;
	localparam int PRIO_W   = 32;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int REQ_W    = 2;
	localparam int STAT_W   = 3;

	// input word: req_type, value_tag, prio_in
	localparam int IN_BITS  = REQ_W + TAG_W + PRIO_W;
	localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
	// output word: status, out_tag, head_tag, head_prio, entry_count, is_empty
	localparam int OUT_BITS = STAT_W + TAG_W + TAG_W + PRIO_W + CNT_W + 1;
	localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

	typedef enum logic [REQ_W-1:0] {
		REQ_ENQ   = 2'd0,
		REQ_DEQ   = 2'd1,
		REQ_CHG   = 2'd2,
		REQ_CLEAR = 2'd3
	} req_e_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK       = 3'd0,
		STAT_EMPTY    = 3'd1,
		STAT_NOTFOUND = 3'd2,
		STAT_RAISED   = 3'd3,
		STAT_FULL     = 3'd4
	} stat_e_t;

	// what every cell does on the coming edge
	typedef enum logic [1:0] {
		CMD_HOLD      = 2'd0,
		CMD_SHIFT_ALL = 2'd1,
		CMD_REMOVE    = 2'd2,
		CMD_INSERT    = 2'd3
	} cmd_e_t;

	typedef struct packed {
		cmd_e_t                    cmd;
		logic [TAG_W-1:0]          key_tag;
		logic signed [PRIO_W-1:0]  key_prio;
		logic                      head_lt;   // head stays ahead of the new entry
	} cell_ctl_t;

endpackage

FILE: hdl/spq_cell.sv
// One slot of the sorted row: holds a tag and a priority, compares them
// against the broadcast key and moves data to or from its neighbors.
// Depends on spq_pkg.
module spq_cell (
	input  logic                              clk,
	input  spq_pkg::cell_ctl_t                ctl,
	input  logic                              occ,
	input  logic                              at_head,
	input  logic [spq_pkg::TAG_W-1:0]         left_tag,
	input  logic signed [spq_pkg::PRIO_W-1:0] left_prio,
	input  logic                              left_b,
	input  logic [spq_pkg::TAG_W-1:0]         right_tag,
	input  logic signed [spq_pkg::PRIO_W-1:0] right_prio,
	input  logic                              seen_in,
	output logic [spq_pkg::TAG_W-1:0]         tag,
	output logic signed [spq_pkg::PRIO_W-1:0] prio,
	output logic                              b_out,
	output logic                              seen_out,
	output logic                              raise_out
);

	logic [spq_pkg::TAG_W-1:0]         tag_q;
	logic signed [spq_pkg::PRIO_W-1:0] prio_q;
	logic                              match;
	logic                              ge;

	// tag search: pass the first-match flag down the row
	assign match     = occ && (tag_q == ctl.key_tag);
	assign seen_out  = seen_in | match;
	assign raise_out = match && !seen_in && (prio_q < ctl.key_prio);

	// insert position: set from the slot where the new entry lands onward
	assign ge    = !occ || (prio_q >= ctl.key_prio);
	assign b_out = at_head ? !ctl.head_lt : (!ctl.head_lt || ge);

	// hold, close a gap from the right, or open one to the left
	always_ff @(posedge clk) begin
		case (ctl.cmd)
			spq_pkg::CMD_SHIFT_ALL: begin
				tag_q  <= right_tag;
				prio_q <= right_prio;
			end
			spq_pkg::CMD_REMOVE: begin
				if (seen_out) begin
					tag_q  <= right_tag;
					prio_q <= right_prio;
				end
			end
			spq_pkg::CMD_INSERT: begin
				if (b_out && !left_b) begin
					tag_q  <= ctl.key_tag;
					prio_q <= ctl.key_prio;
				end else if (left_b) begin
					tag_q  <= left_tag;
					prio_q <= left_prio;
				end
			end
			default: begin
			end
		endcase
	end

	assign tag  = tag_q;
	assign prio = prio_q;

endmodule

FILE: hdl/sorted_priority_queue_unit.sv
// Sorted priority queue built as a row of compare-and-shift cells.
// Each request runs a remove pass, then an insert pass over the row; its result word is
// registered as the insert pass fires, once the output is free, and the next request
// can be accepted then. Reset clears the entry count, the sequencer and the output
// valid flag; slot contents are not cleared and are only read below the entry count.
// Depends on spq_pkg and spq_cell.
module sorted_priority_queue_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [spq_pkg::IN_W-1:0]   s_tdata,   // req_type, value_tag, prio_in
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [spq_pkg::OUT_W-1:0]  m_tdata    // status, out_tag, head_tag, head_prio,
	                                              // entry_count, is_empty
);

	localparam int TW = spq_pkg::TAG_W;
	localparam int PW = spq_pkg::PRIO_W;
	localparam int CW = spq_pkg::CNT_W;
	localparam int N  = spq_pkg::CAPACITY;

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_REMOVE = 3'b010,
		ST_INSERT = 3'b100
	} state_t;

	state_t                   state_q;
	state_t                   state_d;
	spq_pkg::req_e_t          req_q;
	logic [TW-1:0]            key_tag_q;
	logic signed [PW-1:0]     key_prio_q;
	logic [CW-1:0]            count_q;
	logic [CW-1:0]            rm_count;
	spq_pkg::stat_e_t         status_q;
	spq_pkg::stat_e_t         rm_status;
	logic [TW-1:0]            out_tag_q;
	logic [TW-1:0]            rm_out_tag;
	logic                     do_insert_q;
	logic                     rm_insert;
	spq_pkg::cmd_e_t          rm_cmd;
	spq_pkg::cell_ctl_t       ctl;

	logic                     in_acc;
	logic                     out_free;
	logic                     ins_fire;

	logic [N-1:0]             occ;
	logic [TW-1:0]            cell_tag [N];
	logic signed [PW-1:0]     cell_prio [N];
	logic [N-1:0]             cell_b;
	logic [N-1:0]             cell_seen;
	logic [N-1:0]             cell_raise;
	logic                     found;
	logic                     raised;

	logic [CW-1:0]            fin_count;
	logic [TW-1:0]            fin_head_tag;
	logic signed [PW-1:0]     fin_head_prio;

	logic                     m_valid_q;
	spq_pkg::stat_e_t         m_status_q;
	logic [TW-1:0]            m_out_tag_q;
	logic [TW-1:0]            m_head_tag_q;
	logic signed [PW-1:0]     m_head_prio_q;
	logic [CW-1:0]            m_count_q;

	// handshake
	assign out_free = !m_valid_q || m_tready;
	assign ins_fire = (state_q == ST_INSERT) && out_free;
	assign s_tready = (state_q == ST_IDLE) || ins_fire;
	assign in_acc   = s_tvalid && s_tready;

	// sequencer: remove pass, then insert pass
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:   if (in_acc) state_d = ST_REMOVE;
			ST_REMOVE: state_d = ST_INSERT;
			ST_INSERT: begin
				if (ins_fire) state_d = in_acc ? ST_REMOVE : ST_IDLE;
			end
			default:   state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// capture the request word
	always_ff @(posedge clk) begin
		if (in_acc) begin
			req_q      <= spq_pkg::req_e_t'(s_tdata[spq_pkg::REQ_W-1:0]);
			key_tag_q  <= s_tdata[spq_pkg::REQ_W +: TW];
			key_prio_q <= s_tdata[spq_pkg::REQ_W + TW +: PW];
		end
	end

	// occupancy of each slot from the entry count
	for (genvar i = 0; i < N; i++) begin : g_occ
		assign occ[i] = count_q > CW'(i);
	end

	assign found  = cell_seen[N-1];
	assign raised = |cell_raise;

	// remove pass: status, removed tag and what the row does
	always_comb begin
		rm_status  = spq_pkg::STAT_OK;
		rm_out_tag = '0;
		rm_insert  = 1'b0;
		rm_cmd     = spq_pkg::CMD_HOLD;
		rm_count   = count_q;
		case (req_q)
			spq_pkg::REQ_ENQ: begin
				if (count_q >= CW'(N)) rm_status = spq_pkg::STAT_FULL;
				else                   rm_insert = 1'b1;
			end
			spq_pkg::REQ_DEQ: begin
				if (count_q == '0) begin
					rm_status = spq_pkg::STAT_EMPTY;
				end else begin
					rm_out_tag = cell_tag[0];
					rm_cmd     = spq_pkg::CMD_SHIFT_ALL;
					rm_count   = count_q - CW'(1);
				end
			end
			spq_pkg::REQ_CHG: begin
				if (count_q == '0) begin
					rm_status = spq_pkg::STAT_EMPTY;
				end else if (!found) begin
					rm_status = spq_pkg::STAT_NOTFOUND;
				end else if (raised) begin
					rm_status = spq_pkg::STAT_RAISED;
				end else begin
					rm_cmd    = spq_pkg::CMD_REMOVE;
					rm_count  = count_q - CW'(1);
					rm_insert = 1'b1;
				end
			end
			spq_pkg::REQ_CLEAR: rm_count = '0;
			default: begin
			end
		endcase
	end

	// broadcast to the row
	always_comb begin
		ctl.key_tag  = key_tag_q;
		ctl.key_prio = key_prio_q;
		ctl.head_lt  = occ[0] && !(cell_prio[0] > key_prio_q);
		ctl.cmd      = spq_pkg::CMD_HOLD;
		if (state_q == ST_REMOVE)              ctl.cmd = rm_cmd;
		else if (ins_fire && do_insert_q)      ctl.cmd = spq_pkg::CMD_INSERT;
	end

	// the row of cells
	for (genvar i = 0; i < N; i++) begin : g_cell
		logic [TW-1:0]        l_tag;
		logic signed [PW-1:0] l_prio;
		logic                 l_b;
		logic [TW-1:0]        r_tag;
		logic signed [PW-1:0] r_prio;
		logic                 s_in;

		if (i == 0) begin : g_first
			assign l_tag  = '0;
			assign l_prio = '0;
			assign l_b    = 1'b0;
			assign s_in   = 1'b0;
		end else begin : g_mid
			assign l_tag  = cell_tag[i-1];
			assign l_prio = cell_prio[i-1];
			assign l_b    = cell_b[i-1];
			assign s_in   = cell_seen[i-1];
		end
		if (i == N-1) begin : g_last
			assign r_tag  = '0;
			assign r_prio = '0;
		end else begin : g_inner
			assign r_tag  = cell_tag[i+1];
			assign r_prio = cell_prio[i+1];
		end

		spq_cell u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.occ        (occ[i]),
			.at_head    (i == 0),
			.left_tag   (l_tag),
			.left_prio  (l_prio),
			.left_b     (l_b),
			.right_tag  (r_tag),
			.right_prio (r_prio),
			.seen_in    (s_in),
			.tag        (cell_tag[i]),
			.prio       (cell_prio[i]),
			.b_out      (cell_b[i]),
			.seen_out   (cell_seen[i]),
			.raise_out  (cell_raise[i])
		);
	end

	// carry the remove-pass outcome into the insert pass
	always_ff @(posedge clk) begin
		if (state_q == ST_REMOVE) begin
			status_q    <= rm_status;
			out_tag_q   <= rm_out_tag;
			do_insert_q <= rm_insert;
		end
	end

	// entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (state_q == ST_REMOVE) begin
			count_q <= rm_count;
		end else if (ins_fire && do_insert_q) begin
			count_q <= count_q + CW'(1);
		end
	end

	// head after the insert pass
	always_comb begin
		fin_count     = count_q + CW'(do_insert_q);
		fin_head_tag  = cell_tag[0];
		fin_head_prio = cell_prio[0];
		if (do_insert_q && !ctl.head_lt) begin
			fin_head_tag  = key_tag_q;
			fin_head_prio = key_prio_q;
		end
		if (fin_count == '0) begin
			fin_head_tag  = '0;
			fin_head_prio = '0;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (ins_fire) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ins_fire) begin
			m_status_q    <= status_q;
			m_out_tag_q   <= out_tag_q;
			m_head_tag_q  <= fin_head_tag;
			m_head_prio_q <= fin_head_prio;
			m_count_q     <= fin_count;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {
		(spq_pkg::OUT_W - spq_pkg::OUT_BITS)'(0),
		(m_count_q == '0),
		m_count_q,
		m_head_prio_q,
		m_head_tag_q,
		m_out_tag_q,
		m_status_q
	};

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(N))
		else $error("entry count above capacity");

	a_insert_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(ins_fire && do_insert_q) |=> (count_q == $past(count_q) + CW'(1)))
		else $error("insert pass did not add one entry");

	a_fail_no_tag: assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && m_status_q != spq_pkg::STAT_OK) |-> (m_out_tag_q == '0))
		else $error("removed tag reported on a failed request");

	a_empty_head: assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && m_count_q == '0) |-> (m_head_tag_q == '0 && m_head_prio_q == '0))
		else $error("head reported on an empty queue");

	a_insert_room: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.cmd == spq_pkg::CMD_INSERT) |-> (count_q < CW'(N)))
		else $error("insert into a full row");
`endif

endmodule

FILE: tb/sv/sorted_priority_queue_unit_tb.sv
// Self-checking bench for sorted_priority_queue_unit: directed and random requests
// over the stream ports, checked against an in-bench model of the queue.
// Depends on spq_pkg and the unit under test.
module sorted_priority_queue_unit_tb;
	import spq_pkg::*;

	localparam int LIMIT_CYCLES = 200000;
	localparam int RANDOM_ITEMS = 1130;

	// result word layout, lowest bit first
	localparam int OT_LSB  = STAT_W;
	localparam int HT_LSB  = OT_LSB + TAG_W;
	localparam int HP_LSB  = HT_LSB + TAG_W;
	localparam int CNT_LSB = HP_LSB + PRIO_W;
	localparam int EMP_LSB = CNT_LSB + CNT_W;

	localparam logic signed [PRIO_W-1:0] PRIO_MIN = {1'b1, {(PRIO_W-1){1'b0}}};
	localparam logic signed [PRIO_W-1:0] PRIO_MAX = {1'b0, {(PRIO_W-1){1'b1}}};

	typedef struct {
		stat_e_t                   status;
		logic [TAG_W-1:0]          out_tag;
		logic [TAG_W-1:0]          head_tag;
		logic signed [PRIO_W-1:0]  head_prio;
		logic [CNT_W-1:0]          count;
		logic                      is_empty;
	} queue_result_t;

	typedef enum {MODE_FILL, MODE_DRAIN, MODE_MIX} traffic_mode_e;

	// Queue model, expected result words and error bookkeeping
	class queue_board;
		logic [TAG_W-1:0]         tag_slot[CAPACITY];
		logic signed [PRIO_W-1:0] prio_slot[CAPACITY];
		int                       fill;
		queue_result_t            awaited_results[$];
		int                       errors;
		int                       checked;
		int                       status_seen[5];
		int                       req_seen[4];

		function new();
			fill = 0;
			errors = 0;
			checked = 0;
			foreach (status_seen[i]) status_seen[i] = 0;
			foreach (req_seen[i]) req_seen[i] = 0;
		endfunction

		// close the gap left by slot idx
		function void drop_slot(int idx);
			for (int i = idx; i + 1 < fill; i++) begin
				tag_slot[i] = tag_slot[i+1];
				prio_slot[i] = prio_slot[i+1];
			end
			fill--;
		endfunction

		// head if empty or head is greater, else before first non-head entry >= prio
		function void place_entry(logic [TAG_W-1:0] tag, logic signed [PRIO_W-1:0] prio);
			int pos;
			if (fill == 0 || prio_slot[0] > prio) begin
				pos = 0;
			end else begin
				pos = 1;
				while (pos < fill && prio_slot[pos] < prio) pos++;
			end
			for (int i = fill; i > pos; i--) begin
				tag_slot[i] = tag_slot[i-1];
				prio_slot[i] = prio_slot[i-1];
			end
			tag_slot[pos] = tag;
			prio_slot[pos] = prio;
			fill++;
		endfunction

		// apply one accepted request and queue the result it must produce
		function void note_request(req_e_t req, logic [TAG_W-1:0] tag,
				logic signed [PRIO_W-1:0] prio);
			queue_result_t r;
			int            idx;
			r.status = STAT_OK;
			r.out_tag = '0;
			req_seen[int'(req)]++;
			case (req)
				REQ_ENQ: begin
					if (fill >= CAPACITY) r.status = STAT_FULL;
					else place_entry(tag, prio);
				end
				REQ_DEQ: begin
					if (fill == 0) begin
						r.status = STAT_EMPTY;
					end else begin
						r.out_tag = tag_slot[0];
						drop_slot(0);
					end
				end
				REQ_CHG: begin
					if (fill == 0) begin
						r.status = STAT_EMPTY;
					end else begin
						idx = 0;
						while (idx < fill && tag_slot[idx] != tag) idx++;
						if (idx >= fill) begin
							r.status = STAT_NOTFOUND;
						end else if (prio_slot[idx] < prio) begin
							r.status = STAT_RAISED;
						end else begin
							drop_slot(idx);
							place_entry(tag, prio);
						end
					end
				end
				default: fill = 0;
			endcase
			r.head_tag = (fill > 0) ? tag_slot[0] : '0;
			r.head_prio = (fill > 0) ? prio_slot[0] : '0;
			r.count = CNT_W'(fill);
			r.is_empty = (fill == 0);
			status_seen[int'(r.status)]++;
			awaited_results.push_back(r);
		endfunction

		task report(string what, logic [63:0] got, logic [63:0] want);
			errors++;
			if (errors <= 25)
				$display("ERROR word %0d %s: got %0h want %0h", checked, what, got, want);
		endtask

		// compare one accepted result word with the oldest expectation
		task check_result(logic [OUT_W-1:0] w);
			queue_result_t r;
			if (awaited_results.size() == 0) begin
				report("result with no request pending", 64'(w[OUT_BITS-1:0]), 0);
				return;
			end
			r = awaited_results.pop_front();
			if (w[STAT_W-1:0] !== r.status) report("status", w[STAT_W-1:0], r.status);
			if (w[OT_LSB +: TAG_W] !== r.out_tag)
				report("out_tag", w[OT_LSB +: TAG_W], r.out_tag);
			if (w[HT_LSB +: TAG_W] !== r.head_tag)
				report("head_tag", w[HT_LSB +: TAG_W], r.head_tag);
			if (w[HP_LSB +: PRIO_W] !== r.head_prio)
				report("head_prio", w[HP_LSB +: PRIO_W], r.head_prio);
			if (w[CNT_LSB +: CNT_W] !== r.count)
				report("entry_count", w[CNT_LSB +: CNT_W], r.count);
			if (w[EMP_LSB] !== r.is_empty) report("is_empty", w[EMP_LSB], r.is_empty);
			checked++;
		endtask
	endclass

	logic              clk;
	logic              arst_n;
	logic              s_tvalid;
	logic              s_tready;
	logic [IN_W-1:0]   s_tdata;
	logic              m_tvalid;
	logic              m_tready;
	logic [OUT_W-1:0]  m_tdata;

	queue_board    sb;
	int            send_pct;
	int            stall_pct;
	int            cycle_cnt;
	traffic_mode_e mode;
	int            mode_left;

	sorted_priority_queue_unit uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Abort a hung run
	initial cycle_cnt = 0;
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > LIMIT_CYCLES) begin
			$display("timeout after %0d cycles", cycle_cnt);
			$display("sorted_priority_queue_unit: mismatch");
			$finish;
		end
	end

	// Take result words and throttle m_tready
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) sb.check_result(m_tdata);
			m_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Present one request word, hold it until accepted, then note it
	task automatic send_request(req_e_t req, logic [TAG_W-1:0] tag,
			logic signed [PRIO_W-1:0] prio);
		logic [IN_W-1:0] w;
		w = '0;
		w[REQ_W-1:0] = req;
		w[REQ_W +: TAG_W] = tag;
		w[REQ_W+TAG_W +: PRIO_W] = prio;
		if ($urandom_range(99) < send_pct) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_pct);
		end
		s_tvalid <= 1'b1;
		s_tdata <= w;
		do @(posedge clk); while (!s_tready);
		sb.note_request(req, tag, prio);
	endtask

	function automatic logic signed [PRIO_W-1:0] clamp_prio(longint p);
		if (p < longint'(PRIO_MIN)) return PRIO_MIN;
		if (p > longint'(PRIO_MAX)) return PRIO_MAX;
		return PRIO_W'(p);
	endfunction

	function automatic logic signed [PRIO_W-1:0] pick_prio();
		int roll;
		roll = $urandom_range(99);
		if (roll < 3) return PRIO_MIN;
		if (roll < 6) return PRIO_MAX;
		if (roll < 60) return clamp_prio(longint'($urandom_range(12)) - 6);
		if (roll < 85) return clamp_prio(longint'($urandom_range(2000)) - 1000);
		return $urandom;
	endfunction

	function automatic logic [TAG_W-1:0] pick_tag();
		if ($urandom_range(1)) return TAG_W'($urandom_range(15));
		return $urandom;
	endfunction

	// One random request, weighted by the current traffic mode
	task automatic random_request();
		req_e_t                   req;
		logic [TAG_W-1:0]         tag;
		logic signed [PRIO_W-1:0] prio;
		int                       roll;
		int                       k;
		int                       r2;
		roll = $urandom_range(99);
		// advance the mode: fill to full, drain to empty, mix for a while
		if (mode == MODE_FILL && sb.fill == CAPACITY && roll < 12) begin
			mode = MODE_DRAIN;
		end else if (mode == MODE_DRAIN && sb.fill == 0 && roll < 35) begin
			mode = MODE_MIX;
			mode_left = 30 + $urandom_range(40);
		end else if (mode == MODE_MIX) begin
			mode_left--;
			if (mode_left <= 0) mode = MODE_FILL;
		end
		roll = $urandom_range(99);
		case (mode)
			MODE_FILL:  req = (roll < 85) ? REQ_ENQ : (roll < 90) ? REQ_DEQ : REQ_CHG;
			MODE_DRAIN: req = (roll < 15) ? REQ_ENQ : (roll < 83) ? REQ_DEQ :
				(roll < 98) ? REQ_CHG : REQ_CLEAR;
			default:    req = (roll < 40) ? REQ_ENQ : (roll < 68) ? REQ_DEQ :
				(roll < 97) ? REQ_CHG : REQ_CLEAR;
		endcase
		tag = pick_tag();
		prio = pick_prio();
		// aim most priority changes at a stored entry
		if (req == REQ_CHG && sb.fill > 0 && $urandom_range(99) < 75) begin
			k = $urandom_range(sb.fill - 1);
			tag = sb.tag_slot[k];
			r2 = $urandom_range(99);
			if (r2 < 70)
				prio = clamp_prio(longint'(sb.prio_slot[k]) - $urandom_range(8));
			else if (r2 < 85)
				prio = clamp_prio(longint'(sb.prio_slot[k]) + 1 + $urandom_range(8));
		end
		send_request(req, tag, prio);
	endtask

	initial begin
		sb = new();
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		m_tready <= 1'b0;
		arst_n <= 1'b0;
		send_pct = 0;
		stall_pct = 0;
		mode = MODE_FILL;
		mode_left = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// requests on an empty queue
		send_request(REQ_DEQ, 32'h0000_0001, 0);
		send_request(REQ_CHG, 32'h0000_0001, 0);
		send_request(REQ_CLEAR, 32'hFFFF_FFFF, PRIO_MAX);
		// field extremes, new head, ties with head and with a later entry
		send_request(REQ_ENQ, 32'hFFFF_FFFF, 0);
		send_request(REQ_ENQ, 32'h0000_0000, PRIO_MAX);
		send_request(REQ_ENQ, 32'hA5A5_A5A5, PRIO_MIN);
		send_request(REQ_ENQ, 32'h0000_0001, 0);
		send_request(REQ_ENQ, 32'h0000_0002, PRIO_MIN);
		// change the head entry, keep a priority, miss a tag, raise a priority
		send_request(REQ_CHG, 32'hA5A5_A5A5, PRIO_MIN);
		send_request(REQ_CHG, 32'h0000_0000, PRIO_MAX);
		send_request(REQ_CHG, 32'h1234_5678, 0);
		send_request(REQ_CHG, 32'h0000_0001, 5);
		send_request(REQ_CHG, 32'h0000_0001, PRIO_MIN);
		// duplicate tag: the first match from the head is changed
		send_request(REQ_ENQ, 32'h0000_0001, -1);
		send_request(REQ_CHG, 32'h0000_0001, -100);
		send_request(REQ_DEQ, 0, 0);
		send_request(REQ_DEQ, 0, 0);
		send_request(REQ_CLEAR, 0, 0);
		send_request(REQ_DEQ, 0, 0);
		// lone entry changed while it is the head
		send_request(REQ_ENQ, 32'h5A5A_5A5A, -1);
		send_request(REQ_CHG, 32'h5A5A_5A5A, -2);
		send_request(REQ_DEQ, 0, 0);

		// random traffic under each idling pattern
		for (int phase = 0; phase < 4; phase++) begin
			send_pct = (phase == 1) ? 52 : (phase == 3) ? 16 : 0;
			stall_pct = (phase == 2) ? 52 : (phase == 3) ? 16 : 0;
			for (int n = 0; n < RANDOM_ITEMS / 4; n++) random_request();
		end
		s_tvalid <= 1'b0;

		// drain outstanding results, then watch for strays
		while (sb.awaited_results.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);

		$display("requests: %0d enqueue, %0d dequeue, %0d change, %0d clear; %0d words checked",
			sb.req_seen[REQ_ENQ], sb.req_seen[REQ_DEQ], sb.req_seen[REQ_CHG],
			sb.req_seen[REQ_CLEAR], sb.checked);
		$display("statuses: ok %0d, empty %0d, not found %0d, raised %0d, full %0d; errors %0d",
			sb.status_seen[STAT_OK], sb.status_seen[STAT_EMPTY],
			sb.status_seen[STAT_NOTFOUND], sb.status_seen[STAT_RAISED],
			sb.status_seen[STAT_FULL], sb.errors);
		if (sb.errors == 0) begin
			$display("sorted_priority_queue_unit: match");
		end else begin
			$display("sorted_priority_queue_unit: mismatch");
		end
		$finish;
	end

endmodule

FILE: sim.f
hdl/spq_pkg.sv
hdl/spq_cell.sv
hdl/sorted_priority_queue_unit.sv
tb/sv/sorted_priority_queue_unit_tb.sv
